/* hdl/pldlz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pldlz_pkg
// shared types and token constants of the palmdoc lz77 decompressor
// ----------------------------------------------------------------------------
package pldlz_pkg;

    // token classes of the compressed stream
    localparam logic [7:0] TOK_LIT_HI    = 8'd8;    // 1..8 open a literal run
    localparam logic [7:0] TOK_MATCH_LO  = 8'd128;  // 128..191 open a match
    localparam logic [7:0] TOK_PAIR_LO   = 8'd192;  // 192..255 give space + byte
    localparam logic [7:0] PAIR_SPACE    = 8'h20;
    localparam logic [7:0] PAIR_FLIP     = 8'h80;

    localparam int         LIT_RUN_MAX   = 8;
    localparam int         LIT_IDX_W     = $clog2(LIT_RUN_MAX);
    localparam logic [3:0] MATCH_LEN_MIN = 4'd3;
    localparam int         DIST_W        = 11;
    localparam int         COUNT_W       = 12;

    // result sideband, byte_valid in bit 0
    typedef struct packed {
        logic bad_distance;
        logic run_last;
        logic byte_valid;
    } out_user_t;

endpackage

/* hdl/palmdoc_lz77_decompressor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_top
// streaming palmdoc lz77 decoder, one compressed byte in, decompressed bytes out
// ----------------------------------------------------------------------------
// each input beat carries one compressed byte (s_tdata) and the record end
// flag (s_tlast). the block takes one beat, expands it and only then raises
// s_tready again. plain tokens and each byte of a completed literal run leave
// at one byte per cycle unless the output stalls; a space pair gives a space
// and then its byte; in a match of length 3..10, every byte goes through the
// registered read port of the history ram before it is written back, so
// overlapping copies see their own output. a beat that gives no byte keeps
// s_tready high, but at record end it yields a bare end marker (byte_valid low).
// m_tlast marks the final beat of a record; history state is reset after it.
// the history ram is not cleared: a record only reads what it wrote itself.
// a match with distance zero or beyond the bytes produced so far gives zeros
// flagged with bad_distance.
// ----------------------------------------------------------------------------
module palmdoc_lz77_decompressor_top
    import pldlz_pkg::*;
#(
    parameter int WINDOW_BYTES = 2048
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    input  logic       s_tlast,    // record_last
    // result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,    // record_end
    output logic [2:0] m_tuser     // byte_valid, run_last, bad_distance
);

    localparam int AW = $clog2(WINDOW_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOKEN,
        ST_SPACE,
        ST_HOLD,
        ST_MRD,
        ST_MOUT,
        ST_MARK
    } state_t;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_LIT,
        PH_MATCH
    } phase_t;

    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [3:0]   lit_rem_reg, lit_rem_next;
    logic [3:0]   lit_fill_reg, lit_fill_next;
    logic [5:0]   match_high_reg, match_high_next;
    logic         last_reg, last_next;
    logic [7:0]   tok_reg, tok_next;
    logic [LIT_IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic         bad_reg, bad_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]   hold_reg [LIT_RUN_MAX];
    logic         hold_we;
    logic [LIT_IDX_W-1:0] hold_waddr;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [7:0]   m_byte_reg, m_byte_next;
    out_user_t    m_user_reg, m_user_next;
    logic         m_last_reg, m_last_next;

    // history ram
    logic [7:0]   hist_mem [WINDOW_BYTES];
    logic [7:0]   rd_data_reg;
    logic [AW:0]  rd_diff;
    logic [AW-1:0] rd_addr;
    logic         hist_we;

    // emit path
    logic         emit_req, emit_fire, out_free;
    logic [7:0]   emit_byte;
    out_user_t    emit_user;
    logic         accept;

    // token decode helpers
    logic [3:0]   fill_inc;
    logic [DIST_W-1:0] in_dist;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign fill_inc = lit_fill_reg + 4'd1;
    assign in_dist  = {match_high_reg, s_tdata[7:3]};

    // source address of the next match byte, wraps around the window
    assign rd_diff = {1'b0, wptr_reg} - (AW+1)'(dist_reg);
    always_comb begin
        if (rd_diff[AW]) begin
            rd_addr = AW'(rd_diff + (AW+1)'(WINDOW_BYTES));
        end else begin
            rd_addr = rd_diff[AW-1:0];
        end
    end

    // what the current state puts on the output register
    always_comb begin
        emit_req  = 1'b0;
        emit_byte = 8'd0;
        emit_user = '0;
        case (state_reg)
            ST_TOKEN: begin
                emit_req  = 1'b1;
                emit_byte = tok_reg;
                emit_user = '{bad_distance: 1'b0, run_last: 1'b1, byte_valid: 1'b1};
            end
            ST_SPACE: begin
                emit_req  = 1'b1;
                emit_byte = PAIR_SPACE;
                emit_user = '{bad_distance: 1'b0, run_last: 1'b0, byte_valid: 1'b1};
            end
            ST_HOLD: begin
                emit_req  = 1'b1;
                emit_byte = hold_reg[idx_reg];
                emit_user = '{bad_distance: 1'b0,
                              run_last: ({1'b0, idx_reg} + 4'd1) == cnt_reg,
                              byte_valid: 1'b1};
            end
            ST_MOUT: begin
                emit_req  = 1'b1;
                emit_byte = bad_reg ? 8'd0 : rd_data_reg;
                emit_user = '{bad_distance: bad_reg, run_last: cnt_reg == 4'd1,
                              byte_valid: 1'b1};
            end
            ST_MARK: begin
                emit_req  = 1'b1;
                emit_user = '{bad_distance: 1'b0, run_last: 1'b1, byte_valid: 1'b0};
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign emit_fire = emit_req && out_free;
    assign hist_we   = emit_fire && emit_user.byte_valid;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        lit_rem_next    = lit_rem_reg;
        lit_fill_next   = lit_fill_reg;
        match_high_next = match_high_reg;
        last_next       = last_reg;
        tok_next        = tok_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        dist_next       = dist_reg;
        bad_next        = bad_reg;
        wptr_next       = wptr_reg;
        count_next      = count_reg;
        hold_we         = 1'b0;
        hold_waddr      = lit_fill_reg[LIT_IDX_W-1:0];

        m_tvalid_next   = m_tvalid_reg;
        m_byte_next     = m_byte_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next = s_tlast;
                    case (phase_reg)
                        PH_LIT: begin
                            hold_we = 1'b1;
                            if (fill_inc >= lit_rem_reg) begin
                                cnt_next      = fill_inc;
                                idx_next      = '0;
                                phase_next    = PH_TOKEN;
                                lit_fill_next = 4'd0;
                                lit_rem_next  = 4'd0;
                                state_next    = ST_HOLD;
                            end else begin
                                lit_fill_next = fill_inc;
                                state_next    = s_tlast ? ST_MARK : ST_IDLE;
                            end
                        end
                        PH_MATCH: begin
                            dist_next       = in_dist;
                            cnt_next        = {1'b0, s_tdata[2:0]} + MATCH_LEN_MIN;
                            bad_next        = (in_dist == '0) ||
                                              ({1'b0, in_dist} > count_reg);
                            phase_next      = PH_TOKEN;
                            match_high_next = 6'd0;
                            state_next      = ST_MRD;
                        end
                        default: begin
                            phase_next = PH_TOKEN;
                            if (s_tdata == 8'd0 ||
                                (s_tdata > TOK_LIT_HI && s_tdata < TOK_MATCH_LO)) begin
                                tok_next   = s_tdata;
                                state_next = ST_TOKEN;
                            end else if (s_tdata <= TOK_LIT_HI) begin
                                lit_rem_next  = s_tdata[3:0];
                                lit_fill_next = 4'd0;
                                phase_next    = PH_LIT;
                                state_next    = s_tlast ? ST_MARK : ST_IDLE;
                            end else if (s_tdata >= TOK_PAIR_LO) begin
                                tok_next   = s_tdata ^ PAIR_FLIP;
                                state_next = ST_SPACE;
                            end else begin
                                match_high_next = s_tdata[5:0];
                                phase_next      = PH_MATCH;
                                state_next      = s_tlast ? ST_MARK : ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_MRD: begin
                // read port captures the source byte on this edge
                state_next = ST_MOUT;
            end
            default: begin
                if (emit_fire) begin
                    case (state_reg)
                        ST_SPACE: state_next = ST_TOKEN;
                        ST_HOLD:  idx_next   = idx_reg + 1'b1;
                        ST_MOUT: begin
                            cnt_next   = cnt_reg - 4'd1;
                            state_next = ST_MRD;
                        end
                        default:  state_next = state_reg;
                    endcase
                end
            end
        endcase

        if (emit_fire) begin
            m_tvalid_next = 1'b1;
            m_byte_next   = emit_byte;
            m_user_next   = emit_user;
            m_last_next   = emit_user.run_last && last_reg;
            if (emit_user.byte_valid) begin
                wptr_next = (wptr_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wptr_reg + 1'b1;
                if (count_reg != '1) begin
                    count_next = count_reg + 1'b1;
                end
            end
            if (emit_user.run_last) begin
                state_next = ST_IDLE;
                if (last_reg) begin
                    // record done: decoder back to its reset state
                    wptr_next       = '0;
                    count_next      = '0;
                    phase_next      = PH_TOKEN;
                    lit_rem_next    = 4'd0;
                    lit_fill_next   = 4'd0;
                    match_high_next = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_TOKEN;
            lit_rem_reg    <= 4'd0;
            lit_fill_reg   <= 4'd0;
            match_high_reg <= 6'd0;
            wptr_reg       <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            lit_rem_reg    <= lit_rem_next;
            lit_fill_reg   <= lit_fill_next;
            match_high_reg <= match_high_next;
            wptr_reg       <= wptr_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        // payload, no reset
        last_reg   <= last_next;
        tok_reg    <= tok_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        dist_reg   <= dist_next;
        bad_reg    <= bad_next;
        m_byte_reg <= m_byte_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        if (hold_we) begin
            hold_reg[hold_waddr] <= s_tdata;
        end
    end

    // history ram, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wptr_reg] <= emit_byte;
        end
        if (state_reg == ST_MRD) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    // an end marker beat carries nothing but the end flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0 && !m_tuser[2] && m_tuser[1] && m_tlast)
        else $error("end marker beat malformed");

    // the record end beat is always the last beat of its input byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("record end without run_last");

    // a record end input beat always takes the block out of idle (s_tready low)
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("record end beat produced no result");
`endif

endmodule
